// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property must hold at every clock edge outside reset
`define SWRM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SWRM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define SWRM_ASSERT(lbl, clk, rst, prop, msg)

`define SWRM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ----- design/swrm_pkg.sv -----
// ---------------------------------------------------------------------------
// swrm_pkg
// shared types and constants of the sliding window rate meter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package swrm_pkg;

   // field widths
   localparam int BYTES_W  = 48;
   localparam int TIME_W   = 48;
   localparam int RATE_W   = 48;
   localparam int WINDOW_W = 20;

   // scaled byte delta: bytes * 1000 stays below 2^58
   localparam int NUMER_W   = 58;
   localparam int DIV_STEPS = NUMER_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(2000);
   localparam logic [NUMER_W-1:0]  MS_PER_S     = NUMER_W'(1000);

   // operation codes
   localparam logic OP_QUERY  = 1'b0;
   localparam logic OP_RECORD = 1'b1;

   // input transaction
   typedef struct packed {
      logic               operation;
      logic [BYTES_W-1:0] byte_count;
      logic [TIME_W-1:0]  now_ms;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [RATE_W-1:0] rate_bps;
      logic              rate_valid;
   } rsp_type;

   // one ring entry
   typedef struct packed {
      logic [BYTES_W-1:0] bytes;
      logic [TIME_W-1:0]  times;
   } sample_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NEWEST,
      ST_NEWEST_CAP,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_CHECK,
      ST_SCALE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ----- design/swrm_ring.sv -----
// ---------------------------------------------------------------------------
// swrm_ring
// sample ring storage: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrm_ring
   import swrm_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire sample_type    wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output sample_type         rd_data
);

   sample_type mem_ff [DEPTH];
   sample_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/swrm_divider.sv -----
// ---------------------------------------------------------------------------
// swrm_divider
// restoring radix-2 divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module swrm_divider
   import swrm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [NUMER_W-1:0] numer,
   input  wire logic [TIME_W-1:0]  denom,
   output logic                    done,
   output logic [NUMER_W-1:0]      quot
);

   logic                 busy_ff,  busy_in;
   logic                 done_ff,  done_in;
   logic [DIV_CNT_W-1:0] count_ff, count_in;
   logic [TIME_W-1:0]    rem_ff,   rem_in;
   logic [NUMER_W-1:0]   quot_ff,  quot_in;
   logic [TIME_W-1:0]    denom_ff, denom_in;
   logic [TIME_W:0]      trial;
   logic [TIME_W:0]      diff;
   logic                 fits;

   // one shift-subtract step
   always_comb begin
      trial = {rem_ff, quot_ff[NUMER_W-1]};
      diff  = trial - {1'b0, denom_ff};
      fits  = trial >= {1'b0, denom_ff};
   end

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      denom_in = denom_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quot_in  = numer;
         denom_in = denom;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
         quot_in  = {quot_ff[NUMER_W-2:0], fits};
         count_in = count_ff + DIV_CNT_W'(1);
         if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quot_ff  <= quot_in;
      denom_ff <= denom_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// ----- design/sliding_window_rate_meter.sv -----
// ---------------------------------------------------------------------------
// sliding_window_rate_meter
// throughput over a time window from a ring of cumulative byte samples
// ---------------------------------------------------------------------------
//
//   port group | direction | handshake           | payload
//   req_*      | in        | req_valid/req_stall | req_type  (operation, byte_count, now_ms)
//   rsp_*      | out       | rsp_valid/rsp_stall | rsp_type  (rate_bps, rate_valid)
//   csr_*      | in        | csr_wr_en           | csr_wr_data = window_ms
//
// one transaction at a time; the time for a valid rate grows with k, the number
// of ring entries read before the window start is found (1 to NUM_SAMPLES-1),
// and is set by the ring read loop (ST_SCAN_RD, ST_SCAN_CHK) and the serial
// divider; invalid results finish without starting the divider.
// reset empties the ring through the fill count, no clearing pass is needed.
// the result register lets the next transaction start while a result is held
// under rsp_stall.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sliding_window_rate_meter
   import swrm_pkg::*;
#(
   parameter int NUM_SAMPLES = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire req_type             req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output rsp_type                  rsp_data,
   input  wire logic                csr_wr_en,
   input  wire logic [WINDOW_W-1:0] csr_wr_data
);

   localparam int AW = $clog2(NUM_SAMPLES);
   localparam int CW = $clog2(NUM_SAMPLES + 1);

   // control registers
   state_type            state_ff,  state_in;
   logic [AW-1:0]        slot_ff,   slot_in;
   logic [CW-1:0]        fill_ff,   fill_in;
   logic [WINDOW_W-1:0]  window_ff, window_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic [TIME_W-1:0]    cutoff_ff, cutoff_in;
   sample_type           newest_ff, newest_in;
   sample_type           chosen_ff, chosen_in;
   logic [AW-1:0]        ptr_ff,    ptr_in;
   logic [CW-1:0]        remain_ff, remain_in;
   logic [BYTES_W-1:0]   db_ff,     db_in;
   logic [TIME_W-1:0]    dt_ff,     dt_in;
   logic [NUMER_W-1:0]   numer_ff,  numer_in;
   logic [RATE_W-1:0]    res_rate_ff, res_rate_in;
   logic                 res_ok_ff,   res_ok_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   // sequencer outputs
   logic                 accept;
   logic                 mem_wr_en;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   sample_type           mem_wr_data;
   sample_type           mem_rd_data;
   logic                 div_start;
   logic                 div_done;
   logic [NUMER_W-1:0]   div_quot;
   logic                 rsp_load;

   // derived conditions
   logic [AW-1:0]        newest_addr;
   logic [CW:0]          first_wide;
   logic                 too_few;
   logic                 hit;
   logic                 last_entry;
   logic                 bad_pair;
   logic [TIME_W-1:0]    win_ext;

   assign accept = req_valid && !req_stall;

   // ring addresses and checks
   always_comb begin
      newest_addr = (slot_ff == '0) ? AW'(NUM_SAMPLES - 1) : slot_ff - AW'(1);
      if ({1'b0, (CW)'(slot_ff)} >= {1'b0, fill_ff}) begin
         first_wide = {1'b0, (CW)'(slot_ff)} - {1'b0, fill_ff};
      end else begin
         first_wide = {1'b0, (CW)'(slot_ff)} + (CW+1)'(NUM_SAMPLES) - {1'b0, fill_ff};
      end
      too_few    = fill_ff < CW'(2);
      hit        = mem_rd_data.times >= cutoff_ff;
      last_entry = remain_ff == CW'(1);
      bad_pair   = (newest_ff.times <= chosen_ff.times) ||
                   (newest_ff.bytes < chosen_ff.bytes);
      win_ext    = TIME_W'(window_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_NEWEST;
         end
         ST_NEWEST: begin
            state_in = too_few ? ST_FINISH : ST_NEWEST_CAP;
         end
         ST_NEWEST_CAP: state_in = ST_SCAN_RD;
         ST_SCAN_RD:    state_in = ST_SCAN_CHK;
         ST_SCAN_CHK: begin
            if (hit)             state_in = ST_CHECK;
            else if (last_entry) state_in = ST_FINISH;
            else                 state_in = ST_SCAN_RD;
         end
         ST_CHECK: begin
            state_in = bad_pair ? ST_FINISH : ST_SCALE;
         end
         ST_SCALE:  state_in = ST_DIV_GO;
         ST_DIV_GO: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_stall   = 1'b1;
      mem_rd_en   = 1'b0;
      mem_rd_addr = ptr_ff;
      div_start   = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_NEWEST: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = newest_addr;
         end
         ST_SCAN_RD: mem_rd_en = 1'b1;
         ST_DIV_GO:  div_start = 1'b1;
         ST_FINISH:  rsp_load  = !rsp_valid_ff || !rsp_stall;
         default: ;
      endcase
   end

   assign mem_wr_en   = accept && (req_data.operation == OP_RECORD);
   assign mem_wr_data = '{bytes: req_data.byte_count, times: req_data.now_ms};

   // datapath next values
   always_comb begin
      slot_in     = slot_ff;
      fill_in     = fill_ff;
      window_in   = csr_wr_en ? csr_wr_data : window_ff;
      cutoff_in   = cutoff_ff;
      newest_in   = newest_ff;
      chosen_in   = chosen_ff;
      ptr_in      = ptr_ff;
      remain_in   = remain_ff;
      db_in       = db_ff;
      dt_in       = dt_ff;
      numer_in    = numer_ff;
      res_rate_in = res_rate_ff;
      res_ok_in   = res_ok_ff;
      rsp_data_in = rsp_data_ff;

      // sample write and window start
      if (accept) begin
         cutoff_in = (req_data.now_ms > win_ext) ? req_data.now_ms - win_ext : '0;
         if (mem_wr_en) begin
            slot_in = (slot_ff == AW'(NUM_SAMPLES - 1)) ? '0 : slot_ff + AW'(1);
            if (fill_ff != CW'(NUM_SAMPLES)) fill_in = fill_ff + CW'(1);
         end
      end

      case (state_ff)
         ST_NEWEST: begin
            ptr_in      = first_wide[AW-1:0];
            remain_in   = fill_ff - CW'(1);
            res_ok_in   = 1'b0;
            res_rate_in = '0;
         end
         ST_NEWEST_CAP: newest_in = mem_rd_data;
         ST_SCAN_CHK: begin
            chosen_in = mem_rd_data;
            remain_in = remain_ff - CW'(1);
            ptr_in    = (ptr_ff == AW'(NUM_SAMPLES - 1)) ? '0 : ptr_ff + AW'(1);
         end
         ST_CHECK: begin
            db_in = newest_ff.bytes - chosen_ff.bytes;
            dt_in = newest_ff.times - chosen_ff.times;
         end
         ST_SCALE: numer_in = NUMER_W'(db_ff) * MS_PER_S;
         ST_DIV_WAIT: begin
            if (div_done) begin
               res_ok_in   = 1'b1;
               res_rate_in = (div_quot[NUMER_W-1:RATE_W] != '0) ? '1 : div_quot[RATE_W-1:0];
            end
         end
         default: ;
      endcase

      if (rsp_load) begin
         rsp_data_in = '{rate_bps: res_rate_ff, rate_valid: res_ok_ff};
      end
   end

   // result handshake
   always_comb begin
      if (rsp_load)        rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= '0;
         fill_ff      <= '0;
         window_ff    <= WINDOW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload state
   always_ff @(posedge clock) begin
      cutoff_ff   <= cutoff_in;
      newest_ff   <= newest_in;
      chosen_ff   <= chosen_in;
      ptr_ff      <= ptr_in;
      remain_ff   <= remain_in;
      db_ff       <= db_in;
      dt_ff       <= dt_in;
      numer_ff    <= numer_in;
      res_rate_ff <= res_rate_in;
      res_ok_ff   <= res_ok_in;
      rsp_data_ff <= rsp_data_in;
   end

   // sample ring
   swrm_ring #(
      .DEPTH (NUM_SAMPLES),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (slot_ff),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // serial divider
   swrm_divider u_divider (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (numer_ff),
      .denom (dt_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `SWRM_ASSERT(a_fill_bound, clock, reset, fill_ff <= CW'(NUM_SAMPLES), "fill count above ring depth")
   `SWRM_ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff == ST_NEWEST, "transaction did not start ring read")
   `SWRM_ASSERT(a_no_overwrite, clock, reset, !rsp_load || !rsp_valid_ff || !rsp_stall, "result overwritten while stalled")
   `SWRM_ASSERT(a_invalid_zero, clock, reset, !rsp_valid || rsp_data.rate_valid || (rsp_data.rate_bps == '0), "invalid result with nonzero rate")
   `SWRM_ASSERT_NEXT(a_div_done_finish, clock, reset, (state_ff == ST_DIV_WAIT) && div_done, res_ok_ff && (state_ff == ST_FINISH), "divider result not taken")

endmodule

`default_nettype wire
